### rtl/tafc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tafc_pkg: shared types and constants
// Opcodes, widths and limits for the task accounting table.
// ----------------------------------------------------------------------------
package tafc_pkg;
    localparam int TASK_SLOTS = 16;
    localparam int SLOT_BITS  = 4;
    localparam int COUNT_BITS = 48;
    localparam int OPS_BITS   = 32;
    localparam int FAIR_BITS  = 20;
    localparam int NICE_BITS  = 6;

    typedef enum logic [2:0] {
        OP_REGISTER = 3'd0,
        OP_RUN      = 3'd1,
        OP_YIELD    = 3'd2,
        OP_ALLOC    = 3'd3,
        OP_FREE     = 3'd4,
        OP_READ     = 3'd5,
        OP_FAIR     = 3'd6,
        OP_NONE     = 3'd7
    } opcode_t;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [OPS_BITS-1:0]   OPS_MAX = {OPS_BITS{1'b1}};
    localparam logic [16:0]           FAIR_ONE = 17'd65536;
endpackage
`default_nettype wire

### rtl/tafc_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tafc_divider: shared restoring divider
// 64-bit numerator over 64-bit denominator, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tafc_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] numer,
    input  wire logic [63:0] denom,
    output logic             done,
    output logic [63:0]      quot
);
    logic [63:0] q_reg;
    logic [64:0] r_reg;
    logic [63:0] d_reg;
    logic [6:0]  cnt_reg;
    logic        run_reg;
    logic [64:0] trial;

    assign trial = {r_reg[63:0], q_reg[63]};
    assign quot  = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done    <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                q_reg   <= numer;
                r_reg   <= '0;
                d_reg   <= denom;
                cnt_reg <= 7'd64;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (trial >= {1'b0, d_reg})
                begin
                    r_reg <= trial - {1'b0, d_reg};
                    q_reg <= {q_reg[62:0], 1'b1};
                end
                else
                begin
                    r_reg <= trial;
                    q_reg <= {q_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

### rtl/task_accounting_fairness_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// task_accounting_fairness_table_core: per-task accounting and fairness
// Slot counters with CFS-style virtual runtime and Jain fairness index.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays
// high until the single result strobe (done) and drops that same cycle.
// The receiver cannot stall: the result strobe is high for one cycle only.
// Register, yield, alloc, free, read, the unused opcode and commands on
// unregistered slots finish from the execute state. Run goes through the
// shared divider for delta*1024/weight, then writes back. Fairness walks
// the table twice (max, then shifted sum and sum of squares), then divides
// on the shared divider. An empty or all-zero table skips the division.
// Both divisions share one divider.
// ----------------------------------------------------------------------------
module task_accounting_fairness_table_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    output logic              done,
    input  wire logic [2:0]   opcode,
    input  wire logic [3:0]   task_slot,
    input  wire logic [31:0]  amount,
    input  wire logic [16:0]  load_weight,
    input  wire logic signed [5:0] nice_level,
    output logic              status,
    output logic [16:0]       fairness_q16,
    output logic [47:0]       run_total_ns,
    output logic [47:0]       virtual_runtime_ns,
    output logic [31:0]       yield_total,
    output logic [47:0]       allocated_bytes,
    output logic [31:0]       allocate_ops,
    output logic [31:0]       free_ops_count,
    output logic signed [5:0] slot_nice
);
    import tafc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_RUN_DIV, S_RUN_WB, S_MAX, S_SHIFT, S_SUM,
        S_NQ, S_FDIV, S_FDONE
    } state_t;

    // slot table; valid bits in flops, counters as small register arrays
    logic [TASK_SLOTS-1:0]   valid_reg;
    logic [COUNT_BITS-1:0]   run_mem   [TASK_SLOTS];
    logic [COUNT_BITS-1:0]   vrun_mem  [TASK_SLOTS];
    logic [COUNT_BITS-1:0]   byte_mem  [TASK_SLOTS];
    logic [OPS_BITS-1:0]     yield_mem [TASK_SLOTS];
    logic [OPS_BITS-1:0]     aop_mem   [TASK_SLOTS];
    logic [OPS_BITS-1:0]     fop_mem   [TASK_SLOTS];
    logic [NICE_BITS-1:0]    nice_mem  [TASK_SLOTS];

    state_t                  state_reg;
    opcode_t                 op_reg;
    logic [SLOT_BITS-1:0]    slot_reg;
    logic [31:0]             amt_reg;
    logic [16:0]             w_reg;
    logic [NICE_BITS-1:0]    nice_reg;
    logic [SLOT_BITS:0]      idx_reg;
    logic [COUNT_BITS-1:0]   max_reg;
    logic [5:0]              sh_reg;
    logic [SLOT_BITS:0]      n_reg;
    logic [25:0]             sum_reg;
    logic [44:0]             sq_reg;
    logic [63:0]             d_reg;

    logic        div_start;
    logic [63:0] div_num, div_den, div_q;
    logic        div_done;

    tafc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_num),
        .denom (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // sum and square of the current walk element
    logic [SLOT_BITS-1:0]  idx;
    logic [COUNT_BITS-1:0] cur_run;
    logic [19:0]           vshift;
    logic [39:0]           vsq;
    logic [COUNT_BITS:0]   vrun_sum;
    logic [COUNT_BITS:0]   run_sum;
    logic [COUNT_BITS:0]   byte_sum;
    logic [51:0]           sum_sq;

    assign idx     = idx_reg[SLOT_BITS-1:0];
    assign cur_run = run_mem[idx];
    assign vshift  = 20'(cur_run >> sh_reg);
    assign vsq     = vshift * vshift;
    assign run_sum  = {1'b0, run_mem[slot_reg]} + {17'd0, amt_reg};
    assign vrun_sum = {1'b0, vrun_mem[slot_reg]} + {1'b0, div_q[COUNT_BITS-1:0]};
    assign byte_sum = {1'b0, byte_mem[slot_reg]} + {17'd0, amt_reg};
    assign sum_sq   = {26'd0, sum_reg} * {26'd0, sum_reg};

    // bit length of max, minus FAIR_BITS when positive
    logic [5:0] len;
    always_comb
    begin
        len = '0;
        for (int b = 0; b < COUNT_BITS; b++)
        begin
            if (max_reg[b])
                len = 6'(b + 1);
        end
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = {22'd0, amt_reg, 10'd0};
        div_den   = {47'd0, (w_reg == 17'd0) ? 17'd1 : w_reg};
        if (state_reg == S_EXEC && op_reg == OP_RUN && valid_reg[slot_reg])
            div_start = 1'b1;
        if (state_reg == S_NQ && sq_reg != '0 && n_reg != '0)
        begin
            div_start = 1'b1;
            div_num   = {sum_sq[47:0], 16'd0};
            div_den   = d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            busy      <= 1'b0;
            done      <= 1'b0;
            status    <= 1'b0;
            fairness_q16       <= '0;
            run_total_ns       <= '0;
            virtual_runtime_ns <= '0;
            yield_total        <= '0;
            allocated_bytes    <= '0;
            allocate_ops       <= '0;
            free_ops_count     <= '0;
            slot_nice          <= '0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= opcode_t'(opcode);
                        slot_reg  <= task_slot;
                        amt_reg   <= amount;
                        w_reg     <= load_weight;
                        nice_reg  <= nice_level;
                        busy      <= 1'b1;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    status <= 1'b0;
                    fairness_q16       <= '0;
                    run_total_ns       <= '0;
                    virtual_runtime_ns <= '0;
                    yield_total        <= '0;
                    allocated_bytes    <= '0;
                    allocate_ops       <= '0;
                    free_ops_count     <= '0;
                    slot_nice          <= '0;
                    state_reg <= S_IDLE;
                    busy      <= 1'b0;
                    done      <= 1'b1;
                    if (op_reg == OP_REGISTER)
                    begin
                        valid_reg[slot_reg] <= 1'b1;
                        run_mem[slot_reg]   <= '0;
                        vrun_mem[slot_reg]  <= '0;
                        byte_mem[slot_reg]  <= '0;
                        yield_mem[slot_reg] <= '0;
                        aop_mem[slot_reg]   <= '0;
                        fop_mem[slot_reg]   <= '0;
                        nice_mem[slot_reg]  <= nice_reg;
                    end
                    else if (op_reg == OP_FAIR)
                    begin
                        busy      <= 1'b1;
                        done      <= 1'b0;
                        idx_reg   <= '0;
                        max_reg   <= '0;
                        state_reg <= S_MAX;
                    end
                    else if (op_reg != OP_NONE && !valid_reg[slot_reg])
                        status <= 1'b1;
                    else
                    begin
                        case (op_reg)
                            OP_RUN:
                            begin
                                busy      <= 1'b1;
                                done      <= 1'b0;
                                state_reg <= S_RUN_DIV;
                            end
                            OP_YIELD:
                                if (yield_mem[slot_reg] != OPS_MAX)
                                    yield_mem[slot_reg] <= yield_mem[slot_reg] + 32'd1;
                            OP_ALLOC:
                            begin
                                byte_mem[slot_reg] <= byte_sum[COUNT_BITS]
                                    ? CNT_MAX : byte_sum[COUNT_BITS-1:0];
                                if (aop_mem[slot_reg] != OPS_MAX)
                                    aop_mem[slot_reg] <= aop_mem[slot_reg] + 32'd1;
                            end
                            OP_FREE:
                                if (fop_mem[slot_reg] != OPS_MAX)
                                    fop_mem[slot_reg] <= fop_mem[slot_reg] + 32'd1;
                            OP_READ:
                            begin
                                run_total_ns       <= run_mem[slot_reg];
                                virtual_runtime_ns <= vrun_mem[slot_reg];
                                yield_total        <= yield_mem[slot_reg];
                                allocated_bytes    <= byte_mem[slot_reg];
                                allocate_ops       <= aop_mem[slot_reg];
                                free_ops_count     <= fop_mem[slot_reg];
                                slot_nice          <= nice_mem[slot_reg];
                            end
                            default: ;
                        endcase
                    end
                end
                S_RUN_DIV:
                    if (div_done)
                        state_reg <= S_RUN_WB;
                S_RUN_WB:
                begin
                    // quotient fits in 42 bits, so only the add can saturate
                    run_mem[slot_reg]  <= run_sum[COUNT_BITS]
                        ? CNT_MAX : run_sum[COUNT_BITS-1:0];
                    vrun_mem[slot_reg] <= vrun_sum[COUNT_BITS]
                        ? CNT_MAX : vrun_sum[COUNT_BITS-1:0];
                    busy      <= 1'b0;
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_MAX:
                begin
                    if (valid_reg[idx] && cur_run > max_reg)
                        max_reg <= cur_run;
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (SLOT_BITS+1)'(TASK_SLOTS - 1))
                        state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    sh_reg    <= (len > 6'(FAIR_BITS)) ? len - 6'(FAIR_BITS) : 6'd0;
                    idx_reg   <= '0;
                    n_reg     <= '0;
                    sum_reg   <= '0;
                    sq_reg    <= '0;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (valid_reg[idx])
                    begin
                        n_reg   <= n_reg + 1'b1;
                        sum_reg <= sum_reg + 26'(vshift);
                        sq_reg  <= sq_reg + 45'(vsq);
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (SLOT_BITS+1)'(TASK_SLOTS - 1))
                        state_reg <= S_NQ;
                    d_reg <= '0;
                end
                S_NQ:
                begin
                    if (d_reg == '0)
                    begin
                        d_reg <= 64'({59'd0, n_reg} * {19'd0, sq_reg});
                        if (n_reg == '0 || sq_reg == '0)
                        begin
                            fairness_q16 <= FAIR_ONE;
                            status    <= 1'b0;
                            busy      <= 1'b0;
                            done      <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                        state_reg <= S_FDIV;
                end
                S_FDIV:
                    if (div_done)
                        state_reg <= S_FDONE;
                S_FDONE:
                begin
                    fairness_q16 <= (div_q > 64'd65536) ? FAIR_ONE : div_q[16:0];
                    status    <= 1'b0;
                    busy      <= 1'b0;
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/tafc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tafc_checker: port-level assertions
// Handshake and result sanity for the accounting table core.
// ----------------------------------------------------------------------------
module tafc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic        status,
    input wire logic [16:0] fairness_q16
);
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");
    a_done_drops: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy high with result strobe");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without transaction");
    a_fair_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> fairness_q16 <= 17'd65536)
        else $error("fairness above one");
    a_fair_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && fairness_q16 != 17'd0) |-> !status)
        else $error("fairness with error status");
endmodule

bind task_accounting_fairness_table_core tafc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .fairness_q16(fairness_q16)
);
`default_nettype wire

### tb/sv/task_accounting_fairness_table_checker.sv
// ----------------------------------------------------------------------------
// task_accounting_fairness_table_checker: result scoreboard
// Watches accepted commands, predicts each result from a private copy of the
// slot table and compares it field by field with the strobed result.
// ----------------------------------------------------------------------------
module task_accounting_fairness_table_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic         busy,
    input  wire logic         done,
    input  wire logic [2:0]   opcode,
    input  wire logic [3:0]   task_slot,
    input  wire logic [31:0]  amount,
    input  wire logic [16:0]  load_weight,
    input  wire logic [5:0]   nice_level,
    input  wire logic         status,
    input  wire logic [16:0]  fairness_q16,
    input  wire logic [47:0]  run_total_ns,
    input  wire logic [47:0]  virtual_runtime_ns,
    input  wire logic [31:0]  yield_total,
    input  wire logic [47:0]  allocated_bytes,
    input  wire logic [31:0]  allocate_ops,
    input  wire logic [31:0]  free_ops_count,
    input  wire logic [5:0]   slot_nice,
    output int                fail_count,
    output int                pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import tafc_pkg::*;

    typedef struct packed {
        logic        status;
        logic [16:0] fair;
        logic [47:0] run_tot;
        logic [47:0] vrun;
        logic [31:0] yields;
        logic [47:0] bytes;
        logic [31:0] allocs;
        logic [31:0] frees;
        logic [5:0]  nice;
    } acct_result_t;

    logic        tbl_valid [TASK_SLOTS];
    logic [47:0] tbl_run   [TASK_SLOTS];
    logic [47:0] tbl_vrun  [TASK_SLOTS];
    logic [47:0] tbl_bytes [TASK_SLOTS];
    logic [31:0] tbl_yield [TASK_SLOTS];
    logic [31:0] tbl_alloc [TASK_SLOTS];
    logic [31:0] tbl_free  [TASK_SLOTS];
    logic [5:0]  tbl_nice  [TASK_SLOTS];

    acct_result_t expected_results[$];

    function automatic logic [47:0] add_sat48(logic [47:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {17'd0, a} + {1'b0, b};
        return (s > {17'd0, CNT_MAX}) ? CNT_MAX : s[47:0];
    endfunction

    function automatic logic [31:0] inc_sat32(logic [31:0] c);
        return (c == OPS_MAX) ? c : c + 32'd1;
    endfunction

    function automatic logic [16:0] jain_index();
        logic [63:0]  peak, v, cnt, sum, sumsq;
        logic [127:0] num, den, q;
        int bitlen, sh;
        peak = 0; cnt = 0; sum = 0; sumsq = 0; bitlen = 0; sh = 0;
        for (int i = 0; i < TASK_SLOTS; i++)
            if (tbl_valid[i] && tbl_run[i] > peak) peak = tbl_run[i];
        while (bitlen < 64 && (peak >> bitlen) != 0) bitlen++;
        if (bitlen > FAIR_BITS) sh = bitlen - FAIR_BITS;
        for (int i = 0; i < TASK_SLOTS; i++)
            if (tbl_valid[i])
            begin
                v = tbl_run[i] >> sh;
                cnt++;
                sum += v;
                sumsq += v * v;
            end
        if (cnt == 0 || sumsq == 0) return FAIR_ONE;
        num = 128'(sum) * sum;
        den = 128'(cnt) * sumsq;
        q = (num << 16) / den;
        return (q > 65536) ? FAIR_ONE : q[16:0];
    endfunction

    // Apply one command to the shadow table and return its result.
    function automatic acct_result_t apply_command(logic [2:0] op, logic [3:0] slot,
                                                   logic [31:0] amt, logic [16:0] wt,
                                                   logic [5:0] nice);
        acct_result_t r;
        logic [63:0] wdiv;
        r = '0;
        if (op == OP_NONE) return r;
        if (op == OP_FAIR)
        begin
            r.fair = jain_index();
            return r;
        end
        if (op == OP_REGISTER)
        begin
            tbl_valid[slot] = 1'b1;
            tbl_run[slot] = 0; tbl_vrun[slot] = 0; tbl_bytes[slot] = 0;
            tbl_yield[slot] = 0; tbl_alloc[slot] = 0; tbl_free[slot] = 0;
            tbl_nice[slot] = nice;
            return r;
        end
        if (!tbl_valid[slot])
        begin
            r.status = 1'b1;
            return r;
        end
        case (op)
            OP_RUN:
            begin
                wdiv = (wt == 0) ? 64'd1 : 64'(wt);
                tbl_run[slot]  = add_sat48(tbl_run[slot], 64'(amt));
                tbl_vrun[slot] = add_sat48(tbl_vrun[slot], (64'(amt) * 1024) / wdiv);
            end
            OP_YIELD: tbl_yield[slot] = inc_sat32(tbl_yield[slot]);
            OP_ALLOC:
            begin
                tbl_bytes[slot] = add_sat48(tbl_bytes[slot], 64'(amt));
                tbl_alloc[slot] = inc_sat32(tbl_alloc[slot]);
            end
            OP_FREE: tbl_free[slot] = inc_sat32(tbl_free[slot]);
            default:
            begin
                r.run_tot = tbl_run[slot];
                r.vrun    = tbl_vrun[slot];
                r.yields  = tbl_yield[slot];
                r.bytes   = tbl_bytes[slot];
                r.allocs  = tbl_alloc[slot];
                r.frees   = tbl_free[slot];
                r.nice    = tbl_nice[slot];
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            tbl_valid[i] = 0; tbl_run[i] = 0; tbl_vrun[i] = 0; tbl_bytes[i] = 0;
            tbl_yield[i] = 0; tbl_alloc[i] = 0; tbl_free[i] = 0; tbl_nice[i] = 0;
        end
    end

    always @(posedge clk)
    begin
        acct_result_t e;
        if (rst_n)
        begin
            // result is checked before the new command so the queue order holds
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result strobe with no transaction outstanding");
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    compare_field("status", e.status, status);
                    compare_field("fairness_q16", e.fair, fairness_q16);
                    compare_field("run_total_ns", e.run_tot, run_total_ns);
                    compare_field("virtual_runtime_ns", e.vrun, virtual_runtime_ns);
                    compare_field("yield_total", e.yields, yield_total);
                    compare_field("allocated_bytes", e.bytes, allocated_bytes);
                    compare_field("allocate_ops", e.allocs, allocate_ops);
                    compare_field("free_ops_count", e.frees, free_ops_count);
                    compare_field("slot_nice", e.nice, slot_nice);
                end
            end
            if (start && !busy)
                expected_results.insert(expected_results.size(),
                    apply_command(opcode, task_slot, amount, load_weight, nice_level));
            pending_count = expected_results.size();
        end
    end
endmodule

### tb/sv/task_accounting_fairness_table_core_tb.sv
// ----------------------------------------------------------------------------
// task_accounting_fairness_table_core_tb: top-level testbench
// Directed corner commands, then random scheduler/memory event traffic with
// random gaps; the checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module task_accounting_fairness_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tafc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_CMDS    = 700;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy, done;
    logic [2:0]  opcode = '0;
    logic [3:0]  task_slot = '0;
    logic [31:0] amount = '0;
    logic [16:0] load_weight = '0;
    logic signed [5:0] nice_level = '0;
    logic        status;
    logic [16:0] fairness_q16;
    logic [47:0] run_total_ns, virtual_runtime_ns, allocated_bytes;
    logic [31:0] yield_total, allocate_ops, free_ops_count;
    logic signed [5:0] slot_nice;
    int          fail_count, pending_count;
    int          idle_cycles = 0;

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task_accounting_fairness_table_core uut (.*);

    task_accounting_fairness_table_checker chk (
        .clk, .rst_n, .start, .busy, .done, .opcode, .task_slot, .amount,
        .load_weight, .nice_level, .status, .fairness_q16, .run_total_ns,
        .virtual_runtime_ns, .yield_total, .allocated_bytes, .allocate_ops,
        .free_ops_count, .slot_nice, .fail_count, .pending_count
    );

    // Watchdog: cycles with neither a command nor a result accepted.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Mostly short gaps, occasionally long, sometimes none at all.
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 9);
        if (n < 4) n = 0;
        else if (n < 9) n = $urandom_range(1, 4);
        else n = $urandom_range(10, 150);
        if (n > 0)
            start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Present one transaction and hold it until the block takes it; start
    // stays high so a following transaction can go back to back.
    task automatic issue(opcode_t op, logic [3:0] slot, logic [31:0] amt,
                         logic [16:0] wt, logic [5:0] nice);
        opcode      <= op;
        task_slot   <= slot;
        amount      <= amt;
        load_weight <= wt;
        nice_level  <= nice;
        start       <= 1'b1;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    // Random event: a weighted mix of all opcodes on random slots.
    task automatic random_command();
        int pick;
        logic [31:0] amt;
        logic [16:0] wt;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: amt = $urandom;
            1: amt = $urandom_range(0, 1000);
            2: amt = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: amt = $urandom_range(0, 2000000);
        endcase
        case ($urandom_range(0, 3))
            0: wt = '0;
            1: wt = 17'h1FFFF;
            default: wt = 17'($urandom);
        endcase
        if (pick < 8)       issue(OP_REGISTER, 4'($urandom), amt, wt, 6'($urandom));
        else if (pick < 40) issue(OP_RUN, 4'($urandom), amt, wt, 6'($urandom));
        else if (pick < 50) issue(OP_YIELD, 4'($urandom), amt, wt, 6'($urandom));
        else if (pick < 62) issue(OP_ALLOC, 4'($urandom), amt, wt, 6'($urandom));
        else if (pick < 70) issue(OP_FREE, 4'($urandom), amt, wt, 6'($urandom));
        else if (pick < 85) issue(OP_READ, 4'($urandom), amt, wt, 6'($urandom));
        else if (pick < 97) issue(OP_FAIR, 4'($urandom), amt, wt, 6'($urandom));
        else                issue(OP_NONE, 4'($urandom), amt, wt, 6'($urandom));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, events on unregistered slots, unused opcode.
        issue(OP_FAIR, 4'd0, '0, '0, '0);
        issue(OP_RUN, 4'd3, 32'd100, 17'd1, '0);
        issue(OP_READ, 4'd3, '0, '0, '0);
        issue(OP_NONE, 4'd15, 32'hFFFF_FFFF, 17'h1FFFF, 6'h3F);
        // Nice extremes, zero and full weight, max deltas.
        issue(OP_REGISTER, 4'd0, '0, '0, 6'(-20));
        issue(OP_REGISTER, 4'd15, 32'hFFFF_FFFF, 17'h1FFFF, 6'd19);
        issue(OP_FAIR, 4'd0, '0, '0, '0);
        issue(OP_RUN, 4'd0, 32'hFFFF_FFFF, 17'd0, '0);
        issue(OP_RUN, 4'd15, 32'd1, 17'h1FFFF, '0);
        issue(OP_YIELD, 4'd0, '0, '0, '0);
        issue(OP_ALLOC, 4'd0, 32'hFFFF_FFFF, '0, '0);
        issue(OP_FREE, 4'd0, '0, '0, '0);
        issue(OP_FAIR, 4'd0, '0, '0, '0);
        issue(OP_READ, 4'd0, '0, '0, '0);
        issue(OP_READ, 4'd15, '0, '0, '0);
        // Re-register clears counters.
        issue(OP_REGISTER, 4'd0, '0, '0, 6'h3F);
        issue(OP_READ, 4'd0, '0, '0, '0);
        // Drive slot 7 into vruntime saturation (just under 2^42 per run at weight
        // zero, so 70 runs pass 2^48); the run total stays far below its limit.
        issue(OP_REGISTER, 4'd7, '0, '0, 6'd5);
        repeat (70) issue(OP_RUN, 4'd7, 32'hFFFF_FFFF, 17'd0, '0);
        issue(OP_READ, 4'd7, '0, '0, '0);
        issue(OP_FAIR, 4'd0, '0, '0, '0);

        // Sender holds off until the block is fully drained.
        drain();

        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            if (i % 100 == 50) drain();
            idle_gap();
            random_command();
        end

        drain();
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
